// ===== hdl/macd_pkg.sv =====
package macd_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int AVG_WIDTH       = 48;
    localparam int GUARD_BITS      = AVG_WIDTH - SAMPLE_WIDTH;
    localparam int DIFF_WIDTH      = AVG_WIDTH + 1;

    localparam int ALPHA_WIDTH     = 17;
    localparam int ALPHA_FRAC      = 16;
    localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = ALPHA_WIDTH'(1 << ALPHA_FRAC);

    localparam int HI_WIDTH        = DIFF_WIDTH - ALPHA_FRAC;
    localparam int PROD_WIDTH      = HI_WIDTH + ALPHA_WIDTH + 1;
    localparam int PART_WIDTH      = ALPHA_FRAC + 1;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_ALPHA  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_ALPHA   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGNAL_ALPHA = 2'd2;

    localparam logic [ALPHA_WIDTH-1:0] SHORT_ALPHA_RESET  = 17'd10082;
    localparam logic [ALPHA_WIDTH-1:0] LONG_ALPHA_RESET   = 17'd4855;
    localparam logic [ALPHA_WIDTH-1:0] SIGNAL_ALPHA_RESET = 17'd13107;

    // round half up to the sample format, then saturate
    function automatic logic signed [SAMPLE_WIDTH-1:0] f_to_output(
        input logic signed [DIFF_WIDTH-1:0] v
    );
        logic signed [DIFF_WIDTH:0]            t;
        logic signed [DIFF_WIDTH-GUARD_BITS:0] s;
        logic                                  over_hi;
        logic                                  over_lo;
        t = {v[DIFF_WIDTH-1], v} + (DIFF_WIDTH+1)'(1 << (GUARD_BITS - 1));
        s = t[DIFF_WIDTH:GUARD_BITS];
        over_hi = !s[DIFF_WIDTH-GUARD_BITS] && (|s[DIFF_WIDTH-GUARD_BITS-1:SAMPLE_WIDTH-1]);
        over_lo = s[DIFF_WIDTH-GUARD_BITS] && !(&s[DIFF_WIDTH-GUARD_BITS-1:SAMPLE_WIDTH-1]);
        if (over_hi) begin
            f_to_output = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else if (over_lo) begin
            f_to_output = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            f_to_output = s[SAMPLE_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== hdl/macd_signal_histogram.sv =====
// A new item is taken only once the previous result has been loaded into the output
// register; a seeding item skips the average updates. Three dependent average updates
// share one multiplier.
// The block takes a new item while the previous result still waits in the output register.
// Reset (synchronous, active low) loads the default factors, clears the averages
// and arms seeding.
module macd_signal_histogram (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [macd_pkg::SAMPLE_WIDTH-1:0]  i_price,
    input  logic                                      i_last_in_series,
    input  logic                                      i_cfg_we,
    input  logic [macd_pkg::CFG_INDEX_WIDTH-1:0]      i_cfg_index,
    input  logic [macd_pkg::ALPHA_WIDTH-1:0]          i_cfg_data,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]  o_macd_value,
    output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]  o_signal_value,
    output logic signed [macd_pkg::SAMPLE_WIDTH-1:0]  o_histogram_value,
    output logic                                      o_series_end
);
    import macd_pkg::*;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_SHORT  = 3'd1;
    localparam logic [2:0] T_LONG   = 3'd2;
    localparam logic [2:0] T_DIFF   = 3'd3;
    localparam logic [2:0] T_SIGNAL = 3'd4;
    localparam logic [2:0] T_HIST   = 3'd5;
    localparam logic [2:0] T_OUT    = 3'd6;

    logic [2:0]                    r_state;
    logic                          r_start;
    logic                          r_seed_pending;
    logic                          r_seeding;
    logic                          r_last;
    logic [ALPHA_WIDTH-1:0]        r_short_alpha;
    logic [ALPHA_WIDTH-1:0]        r_long_alpha;
    logic [ALPHA_WIDTH-1:0]        r_signal_alpha;
    logic signed [AVG_WIDTH-1:0]   r_short;
    logic signed [AVG_WIDTH-1:0]   r_long;
    logic signed [AVG_WIDTH-1:0]   r_signal;
    logic signed [AVG_WIDTH-1:0]   r_x;
    logic signed [AVG_WIDTH-1:0]   r_diff;
    logic signed [DIFF_WIDTH-1:0]  r_hist;
    logic                          r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_macd;
    logic signed [SAMPLE_WIDTH-1:0] r_sig_out;
    logic signed [SAMPLE_WIDTH-1:0] r_hist_out;
    logic                          r_series_end;

    logic                          accept;
    logic                          out_load;
    logic [ALPHA_WIDTH-1:0]        n_alpha_cfg;
    logic signed [DIFF_WIDTH-1:0]  n_diff_wide;
    logic signed [AVG_WIDTH-1:0]   n_diff_sat;
    logic signed [AVG_WIDTH-1:0]   u_prev;
    logic signed [AVG_WIDTH-1:0]   u_target;
    logic [ALPHA_WIDTH-1:0]        u_alpha;
    logic                          u_done;
    logic signed [AVG_WIDTH-1:0]   u_result;

    assign accept   = i_valid && !o_stall;
    assign out_load = (r_state == T_OUT) && (!r_out_valid || !i_stall);

    assign n_alpha_cfg = (i_cfg_data > ALPHA_ONE) ? ALPHA_ONE : i_cfg_data;

    assign n_diff_wide = {r_short[AVG_WIDTH-1], r_short} - {r_long[AVG_WIDTH-1], r_long};
    assign n_diff_sat  = (n_diff_wide[DIFF_WIDTH-1] != n_diff_wide[AVG_WIDTH-1])
                       ? {n_diff_wide[DIFF_WIDTH-1], {(AVG_WIDTH-1){!n_diff_wide[DIFF_WIDTH-1]}}}
                       : n_diff_wide[AVG_WIDTH-1:0];

    always_comb begin
        unique case (r_state)
            T_LONG: begin
                u_prev   = r_long;
                u_target = r_x;
                u_alpha  = r_long_alpha;
            end
            T_SIGNAL: begin
                u_prev   = r_signal;
                u_target = r_diff;
                u_alpha  = r_signal_alpha;
            end
            default: begin
                u_prev   = r_short;
                u_target = r_x;
                u_alpha  = r_short_alpha;
            end
        endcase
    end

    macd_smooth_unit u_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_prev   (u_prev),
        .i_target (u_target),
        .i_alpha  (u_alpha),
        .o_done   (u_done),
        .o_result (u_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_alpha  <= SHORT_ALPHA_RESET;
            r_long_alpha   <= LONG_ALPHA_RESET;
            r_signal_alpha <= SIGNAL_ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SHORT_ALPHA:  r_short_alpha  <= n_alpha_cfg;
                REG_LONG_ALPHA:   r_long_alpha   <= n_alpha_cfg;
                REG_SIGNAL_ALPHA: r_signal_alpha <= n_alpha_cfg;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= T_IDLE;
            r_start        <= 1'b0;
            r_seed_pending <= 1'b1;
            r_seeding      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_short        <= '0;
            r_long         <= '0;
            r_signal       <= '0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_seeding      <= r_seed_pending;
                        r_seed_pending <= i_last_in_series;
                        if (r_seed_pending) begin
                            r_short  <= {i_price, {GUARD_BITS{1'b0}}};
                            r_long   <= {i_price, {GUARD_BITS{1'b0}}};
                            r_signal <= '0;
                            r_state  <= T_DIFF;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= T_SHORT;
                        end
                    end
                end
                T_SHORT: begin
                    if (u_done) begin
                        r_short <= u_result;
                        r_start <= 1'b1;
                        r_state <= T_LONG;
                    end
                end
                T_LONG: begin
                    if (u_done) begin
                        r_long  <= u_result;
                        r_state <= T_DIFF;
                    end
                end
                T_DIFF: begin
                    if (r_seeding) begin
                        r_state <= T_HIST;
                    end else begin
                        r_start <= 1'b1;
                        r_state <= T_SIGNAL;
                    end
                end
                T_SIGNAL: begin
                    if (u_done) begin
                        r_signal <= u_result;
                        r_state  <= T_HIST;
                    end
                end
                T_HIST: begin
                    r_state <= T_OUT;
                end
                T_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= {i_price, {GUARD_BITS{1'b0}}};
            r_last <= i_last_in_series;
        end
        if (r_state == T_DIFF) begin
            r_diff <= n_diff_sat;
        end
        if (r_state == T_HIST) begin
            r_hist <= {r_diff[AVG_WIDTH-1], r_diff} - {r_signal[AVG_WIDTH-1], r_signal};
        end
        if (out_load) begin
            r_macd       <= f_to_output({r_diff[AVG_WIDTH-1], r_diff});
            r_sig_out    <= f_to_output({r_signal[AVG_WIDTH-1], r_signal});
            r_hist_out   <= f_to_output(r_hist);
            r_series_end <= r_last;
        end
    end

    assign o_stall           = (r_state != T_IDLE);
    assign o_valid           = r_out_valid;
    assign o_macd_value      = r_macd;
    assign o_signal_value    = r_sig_out;
    assign o_histogram_value = r_hist_out;
    assign o_series_end      = r_series_end;

    a_done_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (r_state == T_SHORT || r_state == T_LONG || r_state == T_SIGNAL))
        else $error("smooth unit finished outside an average update");

    a_seed_skips_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_seed_pending) |=> (r_state == T_DIFF && !r_start))
        else $error("seeding item started an average update");

    a_seed_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_seeding) |=>
            (o_macd_value == '0 && o_signal_value == '0 && o_histogram_value == '0))
        else $error("seeding item gave a nonzero result");

endmodule

// ===== hdl/macd_smooth_unit.sv =====
module macd_smooth_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [macd_pkg::AVG_WIDTH-1:0]  i_prev,
    input  logic signed [macd_pkg::AVG_WIDTH-1:0]  i_target,
    input  logic [macd_pkg::ALPHA_WIDTH-1:0]       i_alpha,
    output logic                                   o_done,
    output logic signed [macd_pkg::AVG_WIDTH-1:0]  o_result
);
    import macd_pkg::*;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_LO   = 2'd1;
    localparam logic [1:0] U_HI   = 2'd2;
    localparam logic [1:0] U_SUM  = 2'd3;

    logic [1:0]                    r_state;
    logic                          r_done;
    logic signed [AVG_WIDTH-1:0]   r_prev;
    logic [ALPHA_WIDTH-1:0]        r_alpha;
    logic signed [DIFF_WIDTH-1:0]  r_delta;
    logic [PART_WIDTH-1:0]         r_part;
    logic signed [DIFF_WIDTH-1:0]  r_base;
    logic signed [PROD_WIDTH-1:0]  r_prod;
    logic signed [AVG_WIDTH-1:0]   r_result;

    logic signed [HI_WIDTH-1:0]    mul_a;
    logic signed [ALPHA_WIDTH:0]   mul_b;
    logic signed [PROD_WIDTH-1:0]  mul_p;
    logic signed [PROD_WIDTH-1:0]  n_lo_round;
    logic signed [DIFF_WIDTH-1:0]  n_delta;
    logic signed [PROD_WIDTH-1:0]  n_sum;

    assign mul_a = (r_state == U_LO)
                 ? $signed({{(HI_WIDTH-ALPHA_FRAC){1'b0}}, r_delta[ALPHA_FRAC-1:0]})
                 : r_delta[DIFF_WIDTH-1:ALPHA_FRAC];
    assign mul_b = $signed({1'b0, r_alpha});
    assign mul_p = mul_a * mul_b;

    assign n_lo_round = mul_p + $signed(PROD_WIDTH'(1 << (ALPHA_FRAC - 1)));
    assign n_delta    = {i_target[AVG_WIDTH-1], i_target} - {i_prev[AVG_WIDTH-1], i_prev};
    assign n_sum      = {{(PROD_WIDTH-DIFF_WIDTH){r_base[DIFF_WIDTH-1]}}, r_base} + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_state <= U_LO;
                    end
                end
                U_LO: begin
                    r_state <= U_HI;
                end
                U_HI: begin
                    r_state <= U_SUM;
                end
                U_SUM: begin
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == U_IDLE && i_start) begin
            r_prev  <= i_prev;
            r_alpha <= i_alpha;
            r_delta <= n_delta;
        end
        if (r_state == U_LO) begin
            r_part <= n_lo_round[ALPHA_FRAC +: PART_WIDTH];
        end
        if (r_state == U_HI) begin
            r_prod <= mul_p;
            r_base <= {r_prev[AVG_WIDTH-1], r_prev}
                    + $signed({{(DIFF_WIDTH-PART_WIDTH){1'b0}}, r_part});
        end
        if (r_state == U_SUM) begin
            r_result <= n_sum[AVG_WIDTH-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== tb/sv/macd_signal_histogram_test.sv =====
module macd_signal_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    import macd_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     STUCK_LIMIT   = 4000;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 200;
    localparam longint AVG_MAX       = (64'sd1 <<< (AVG_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] price;
        logic                           last;
    } t_price_item;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] macd;
        logic signed [SAMPLE_WIDTH-1:0] signal;
        logic signed [SAMPLE_WIDTH-1:0] histogram;
        logic                           series_end;
    } t_macd_result;

    logic                           i_clk;
    logic                           i_rst_n          = 1'b0;
    logic                           i_valid          = 1'b0;
    logic                           o_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_price          = '0;
    logic                           i_last_in_series = 1'b0;
    logic                           i_cfg_we         = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index      = '0;
    logic [ALPHA_WIDTH-1:0]         i_cfg_data       = '0;
    logic                           o_valid;
    logic                           i_stall          = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_macd_value;
    logic signed [SAMPLE_WIDTH-1:0] o_signal_value;
    logic signed [SAMPLE_WIDTH-1:0] o_histogram_value;
    logic                           o_series_end;

    longint                 short_avg;
    longint                 long_avg;
    longint                 signal_avg;
    bit                     seeding;
    logic [ALPHA_WIDTH-1:0] short_factor;
    logic [ALPHA_WIDTH-1:0] long_factor;
    logic [ALPHA_WIDTH-1:0] signal_factor;

    t_macd_result results_due[$];
    t_price_item  prices_pending[$];
    int           mismatches    = 0;
    bit           idle_on       = 1'b0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           send_gap      = 0;
    int           stall_left    = 0;
    int           stuck_cycles  = 0;

    macd_signal_histogram DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_price           (i_price),
        .i_last_in_series  (i_last_in_series),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_macd_value      (o_macd_value),
        .o_signal_value    (o_signal_value),
        .o_histogram_value (o_histogram_value),
        .o_series_end      (o_series_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_avg(input longint v);
        if (v > AVG_MAX) return AVG_MAX;
        if (v < -AVG_MAX - 1) return -AVG_MAX - 1;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (r > SAMPLE_MAX) r = SAMPLE_MAX;
        else if (r < -SAMPLE_MAX - 1) r = -SAMPLE_MAX - 1;
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    // prev + a*(target - prev), product rounded half up, factor capped at one
    function automatic longint ema_update(input longint prev, input longint target,
                                          input logic [ALPHA_WIDTH-1:0] factor);
        longint d;
        longint a;
        longint hi;
        longint part;
        d    = target - prev;
        a    = (factor > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(factor);
        hi   = d >>> ALPHA_FRAC;
        part = ((d & 64'hFFFF) * a + 32768) >> ALPHA_FRAC;
        return prev + hi * a + part;
    endfunction

    function automatic t_macd_result macd_predict(input logic signed [SAMPLE_WIDTH-1:0] price,
                                                  input logic last);
        longint       x;
        longint       spread;
        t_macd_result r;
        x = longint'(price) <<< GUARD_BITS;
        if (seeding) begin
            short_avg  = x;
            long_avg   = x;
            signal_avg = 0;
        end else begin
            short_avg = ema_update(short_avg, x, short_factor);
            long_avg  = ema_update(long_avg, x, long_factor);
        end
        spread = clamp_avg(short_avg - long_avg);
        if (!seeding) signal_avg = ema_update(signal_avg, spread, signal_factor);
        seeding      = last;
        r.macd       = to_sample(spread);
        r.signal     = to_sample(signal_avg);
        r.histogram  = to_sample(spread - signal_avg);
        r.series_end = last;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        if (roll < 98) return $urandom_range(5, 25);
        return $urandom_range(26, 80);
    endfunction

    function automatic logic [ALPHA_WIDTH-1:0] pick_factor();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALPHA_ONE;
            2: return ALPHA_WIDTH'($urandom_range(ALPHA_ONE + 1, (1 << ALPHA_WIDTH) - 1));
            default: return ALPHA_WIDTH'((2 << ALPHA_FRAC) / ($urandom_range(2, 200) + 1));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_macd_result want;
        if (!i_rst_n) begin
            short_factor  = SHORT_ALPHA_RESET;
            long_factor   = LONG_ALPHA_RESET;
            signal_factor = SIGNAL_ALPHA_RESET;
            short_avg     = 0;
            long_avg      = 0;
            signal_avg    = 0;
            seeding       = 1'b1;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SHORT_ALPHA:  short_factor  = i_cfg_data;
                    REG_LONG_ALPHA:   long_factor   = i_cfg_data;
                    REG_SIGNAL_ALPHA: signal_factor = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual macd_value %0d",
                             $time, o_macd_value);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("macd_value", want.macd, o_macd_value);
                    check_field("signal_value", want.signal, o_signal_value);
                    check_field("histogram_value", want.histogram, o_histogram_value);
                    check_field("series_end", want.series_end, o_series_end);
                end
            end
            if (i_valid && !o_stall) begin
                results_due.push_back(macd_predict(i_price, i_last_in_series));
            end
        end
    end

    always @(posedge i_clk) begin
        t_price_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (prices_pending.size() != 0) begin
                item = prices_pending.pop_front();
                i_price          <= item.price;
                i_last_in_series <= item.last;
                i_valid          <= 1'b1;
                send_gap         <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            i_stall     <= 1'b1;
            stall_left  <= HOLD_CYCLES - 1;
        end else begin
            gap = pick_gap();
            i_stall    <= (gap != 0);
            stall_left <= (gap != 0) ? gap - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_factor(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [ALPHA_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic queue_price(input logic signed [SAMPLE_WIDTH-1:0] price, input logic last);
        t_price_item item;
        item.price = price;
        item.last  = last;
        prices_pending.push_back(item);
    endtask

    task automatic wait_drained();
        while (prices_pending.size() != 0 || i_valid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly random walks with the last flag on the final sample; some noise, partly with random last flags
    task automatic queue_series(input int length);
        int                             mode;
        int                             scale;
        logic signed [SAMPLE_WIDTH-1:0] price;
        logic                           last;
        mode  = $urandom_range(0, 9);
        price = $urandom;
        for (int k = 0; k < length; k++) begin
            if (mode >= 7) begin
                price = $urandom;
            end else if (k != 0) begin
                scale = $urandom_range(0, 24);
                price = price + ($signed($urandom) >>> (31 - scale));
            end
            last = (mode >= 8) ? ($urandom_range(0, 3) == 0) : (k == length - 1);
            queue_price(price, last);
        end
    endtask

    initial begin
        int budget;
        int length;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        queue_price(32'sh7FFFFFFF, 1'b0);
        queue_price(32'sh80000000, 1'b0);
        queue_price(32'sh00010000, 1'b0);
        queue_price(32'shFFFFFFFF, 1'b1);
        queue_price(32'sh00000001, 1'b1);
        queue_price(32'sh00000000, 1'b0);
        queue_price(32'sh7FFFFFFF, 1'b1);
        wait_drained();

        // short tracks the price, long frozen at the seed: spread saturates low
        write_factor(REG_SHORT_ALPHA, ALPHA_ONE);
        write_factor(REG_LONG_ALPHA, '0);
        write_factor(REG_SIGNAL_ALPHA, '1);
        write_factor(REG_UNUSED, '0);
        queue_price(32'sh7FFFFFFF, 1'b0);
        queue_price(32'sh80000000, 1'b0);
        queue_price(32'sh7FFFFFFF, 1'b0);
        queue_price(32'sh80000000, 1'b1);
        wait_drained();

        // spread saturates high, signal frozen at zero
        write_factor(REG_SHORT_ALPHA, '1);
        write_factor(REG_LONG_ALPHA, '0);
        write_factor(REG_SIGNAL_ALPHA, '0);
        queue_price(32'sh80000000, 1'b0);
        queue_price(32'sh7FFFFFFF, 1'b0);
        queue_price(32'sh00000000, 1'b1);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_factor(REG_SHORT_ALPHA, pick_factor());
            write_factor(REG_LONG_ALPHA, pick_factor());
            write_factor(REG_SIGNAL_ALPHA, pick_factor());
            idle_on = (phase != 0 && phase != 3);
            budget  = PHASE_ITEMS;
            while (budget > 0) begin
                length = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
                if (length > budget) length = budget;
                queue_series(length);
                budget -= length;
            end
            if (phase == 3) hold_requests++;
            wait_drained();
        end

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
